FILE: rtl/rlsi_pkg.sv
// Shared types, command codes and character constants for the run-length
// string iterator. No dependencies; all files but rlsi_run_mem import it.
`default_nettype none

package rlsi_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TAKE  = 2'd1,
		CMD_CLEAR = 2'd2
	} rlsi_cmd_t;

	localparam logic [7:0] CHAR_SPACE   = 8'd32;
	localparam logic [7:0] CHAR_ZERO    = 8'd48;
	localparam logic [7:0] CHAR_NINE    = 8'd57;
	localparam logic [7:0] CHAR_UPPER_A = 8'd65;
	localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
	localparam logic [7:0] CHAR_LOWER_A = 8'd97;
	localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
	localparam int         DECIMAL_BASE = 10;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_more;
		logic       table_full;
	} rlsi_result_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
			((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rlsi_run_mem.sv
// Run table storage: one write port and one registered read port, write-first.
// Uses no package items.
`default_nettype none

module rlsi_run_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 40
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// A write to the slot being read shows up on the read data at once.
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rlsi_engine.sv
// Run table state and the combinational load/take/clear step.
// Depends on rlsi_pkg and rlsi_run_mem.
`default_nettype none

module rlsi_engine #(
	parameter int RUN_SLOTS  = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                go,
	input  wire rlsi_pkg::rlsi_cmd_t cmd,
	input  wire logic [7:0]          byte_value,
	output rlsi_pkg::rlsi_result_t   result
);
	import rlsi_pkg::*;

	localparam int IDX_W  = $clog2(RUN_SLOTS);
	localparam int RUNS_W = $clog2(RUN_SLOTS + 1);
	localparam int REM_W  = COUNT_BITS + IDX_W;
	localparam int MUL_W  = COUNT_BITS + 4;
	localparam int ENT_W  = 8 + COUNT_BITS;

	localparam logic [MUL_W-1:0] COUNT_MAX_W = {{4{1'b0}}, {COUNT_BITS{1'b1}}};

	// Control state.
	logic [RUNS_W-1:0]     runs_q, runs_d;
	logic [IDX_W-1:0]      rslot_q, rslot_d;
	logic [COUNT_BITS-1:0] used_q, used_d;
	logic [REM_W-1:0]      remain_q, remain_d;
	logic                  skip_q, skip_d;
	// Copies of the tail run and of the run being read.
	logic [7:0]            tail_letter_q, tail_letter_d;
	logic [COUNT_BITS-1:0] tail_count_q, tail_count_d;
	logic [7:0]            cur_letter_q, cur_letter_d;
	logic [COUNT_BITS-1:0] cur_count_q, cur_count_d;

	logic [RUNS_W-1:0]     tail_full;
	logic [IDX_W-1:0]      tail_idx;
	logic                  has_tail;
	logic                  rs_is_tail;
	logic [IDX_W:0]        nxt_full;
	logic                  nxt_is_tail;
	logic [IDX_W:0]        rd_full;
	logic [IDX_W-1:0]      raddr;
	logic [ENT_W-1:0]      rdata;
	logic [7:0]            eff_cur_letter, eff_nxt_letter;
	logic [COUNT_BITS-1:0] eff_cur_count, eff_nxt_count;

	logic [MUL_W-1:0]      prod;
	logic [COUNT_BITS-1:0] new_count;
	logic [COUNT_BITS-1:0] delta;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [ENT_W-1:0]      wdata;

	assign tail_full   = runs_q - RUNS_W'(1);
	assign tail_idx    = tail_full[IDX_W-1:0];
	assign has_tail    = (runs_q != '0);
	assign rs_is_tail  = has_tail && (rslot_q == tail_idx);
	assign nxt_full    = {1'b0, rslot_q} + (IDX_W + 1)'(1);
	assign nxt_is_tail = has_tail && (nxt_full == {1'b0, tail_idx});

	// The memory always holds the run after the one being read.
	assign rd_full = {1'b0, rslot_d} + (IDX_W + 1)'(1);
	assign raddr   = (rd_full >= (IDX_W + 1)'(RUN_SLOTS)) ? '0 : rd_full[IDX_W-1:0];

	assign eff_cur_letter = rs_is_tail ? tail_letter_q : cur_letter_q;
	assign eff_cur_count  = rs_is_tail ? tail_count_q  : cur_count_q;
	assign eff_nxt_letter = nxt_is_tail ? tail_letter_q : rdata[ENT_W-1:COUNT_BITS];
	assign eff_nxt_count  = nxt_is_tail ? tail_count_q  : rdata[COUNT_BITS-1:0];

	// Decimal accumulation of the tail count, saturating.
	assign prod = (MUL_W'(tail_count_q) << 3) + (MUL_W'(tail_count_q) << 1) +
		MUL_W'(byte_value[3:0]);
	assign new_count = (prod > COUNT_MAX_W) ? {COUNT_BITS{1'b1}} : prod[COUNT_BITS-1:0];
	assign delta     = new_count - tail_count_q;

	always_comb begin
		runs_d        = runs_q;
		rslot_d       = rslot_q;
		used_d        = used_q;
		remain_d      = remain_q;
		skip_d        = skip_q;
		tail_letter_d = tail_letter_q;
		tail_count_d  = tail_count_q;
		cur_letter_d  = eff_cur_letter;
		cur_count_d   = eff_cur_count;
		we            = 1'b0;
		waddr         = tail_idx;
		wdata         = {byte_value, {COUNT_BITS{1'b0}}};
		result        = '{out_char: CHAR_SPACE, has_more: 1'b0, table_full: 1'b0};

		if (go) begin
			unique case (cmd)
				CMD_LOAD: begin
					if (is_letter(byte_value)) begin
						if (has_tail && (tail_count_q == '0)) begin
							// Replace a tail run that never got a count.
							tail_letter_d = byte_value;
							skip_d        = 1'b0;
							we            = 1'b1;
						end else if (runs_q >= RUNS_W'(RUN_SLOTS)) begin
							skip_d            = 1'b1;
							result.table_full = 1'b1;
						end else begin
							tail_letter_d = byte_value;
							tail_count_d  = '0;
							runs_d        = runs_q + RUNS_W'(1);
							skip_d        = 1'b0;
							we            = 1'b1;
							waddr         = runs_q[IDX_W-1:0];
						end
					end else if (is_digit(byte_value) && !skip_q && has_tail) begin
						tail_count_d = new_count;
						remain_d     = remain_q + REM_W'(delta);
						we           = 1'b1;
						wdata        = {tail_letter_q, new_count};
					end
				end
				CMD_TAKE: begin
					if (remain_q != '0) begin
						remain_d = remain_q - REM_W'(1);
						if (used_q >= eff_cur_count) begin
							// Current run used up: the next run has a nonzero count.
							rslot_d         = nxt_full[IDX_W-1:0];
							used_d          = COUNT_BITS'(1);
							cur_letter_d    = eff_nxt_letter;
							cur_count_d     = eff_nxt_count;
							result.out_char = eff_nxt_letter;
						end else begin
							used_d          = used_q + COUNT_BITS'(1);
							result.out_char = eff_cur_letter;
						end
					end
				end
				CMD_CLEAR: begin
					runs_d   = '0;
					rslot_d  = '0;
					used_d   = '0;
					remain_d = '0;
					skip_d   = 1'b0;
				end
				default: begin
				end
			endcase
			result.has_more = (remain_d != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q   <= '0;
			rslot_q  <= '0;
			used_q   <= '0;
			remain_q <= '0;
			skip_q   <= 1'b0;
		end else begin
			runs_q   <= runs_d;
			rslot_q  <= rslot_d;
			used_q   <= used_d;
			remain_q <= remain_d;
			skip_q   <= skip_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			tail_letter_q <= tail_letter_d;
			tail_count_q  <= tail_count_d;
			cur_letter_q  <= cur_letter_d;
			cur_count_q   <= cur_count_d;
		end
	end

	rlsi_run_mem #(
		.DEPTH  (RUN_SLOTS),
		.ADDR_W (IDX_W),
		.DATA_W (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

FILE: rtl/run_length_string_iterator.sv
// Top level of the run-length string iterator: input register, run table
// engine and result register. Depends on rlsi_pkg and rlsi_engine.
//
//  channel  | fields                                   | role
//  ---------+------------------------------------------+----------------------
//  s_*      | tuser: command; tdata: byte_value        | commands and bytes in
//  m_*      | tdata: out_char, has_more, table_full    | one result per item
//
// A new transaction can be taken each cycle while the result is not stalled by m_tready.
// m_tvalid rises when the result register loads: an accepted item sits in the input
// register until the result register is free, which then takes its result.
// The run table is read one slot ahead so a take never waits on memory.
// Reset zeroes the run count, so stale table entries are never read and no
// clearing pass is needed.
// While m_tready is low the result holds and at most one more item is buffered.
`default_nettype none

module run_length_string_iterator #(
	parameter int RUN_SLOTS  = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata    // [7:0] out_char, [8] has_more, [9] table_full
);
	import rlsi_pkg::*;

	logic         v_s1;
	rlsi_cmd_t    cmd_s1;
	logic [7:0]   byte_s1;
	logic         go;
	rlsi_result_t res;
	rlsi_result_t res_q;

	assign go       = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || go;
	assign m_tdata  = {6'b0, res_q.table_full, res_q.has_more, res_q.out_char};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (go) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= rlsi_cmd_t'(s_tuser);
			byte_s1 <= s_tdata;
		end
		if (go) begin
			res_q <= res;
		end
	end

	rlsi_engine #(
		.RUN_SLOTS  (RUN_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.cmd        (cmd_s1),
		.byte_value (byte_s1),
		.result     (res)
	);

endmodule

`default_nettype wire

FILE: rtl/rlsi_checker.sv
// Port-level checks for run_length_string_iterator, attached by bind.
// Depends on rlsi_pkg.
`default_nettype none

module rlsi_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	import rlsi_pkg::*;

	// A result waiting for the sink stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// With the result register empty the input register always drains.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	// A dropped letter gives no character, and any character given is a letter.
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] == CHAR_SPACE && m_tdata[15:10] == 6'b0) ||
			(is_letter(m_tdata[7:0]) && !m_tdata[9] && m_tdata[15:10] == 6'b0))
		else $error("bad result character");

endmodule

bind run_length_string_iterator rlsi_checker u_rlsi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sv/rlsi_scoreboard_pkg.sv
// Scoreboard for the run-length string iterator testbench: a cycle-free
// predictor of the run table and a queue of expected results.
// Depends on rlsi_pkg for the command codes, characters and result type.

package rlsi_scoreboard_pkg;

	import rlsi_pkg::*;

	localparam int          TB_RUN_SLOTS  = 64;
	localparam int          TB_COUNT_BITS = 32;
	localparam logic [63:0] COUNT_CEILING = (64'd1 << TB_COUNT_BITS) - 64'd1;
	localparam int          REPORT_LIMIT  = 10;

	class rlsi_scoreboard;
		logic [7:0]   run_letters [TB_RUN_SLOTS];
		logic [63:0]  run_counts  [TB_RUN_SLOTS];
		int           runs_open;
		int           slot_reading;
		logic [63:0]  used_from_slot;
		logic [63:0]  total_loaded;
		logic [63:0]  total_taken;
		bit           after_dropped;
		rlsi_result_t expected_q [$];
		int           failures;
		int           inputs_seen;
		int           results_seen;

		function new();
			failures     = 0;
			inputs_seen  = 0;
			results_seen = 0;
			empty_table();
		endfunction

		function void empty_table();
			foreach (run_letters[i]) begin
				run_letters[i] = '0;
				run_counts[i]  = '0;
			end
			runs_open      = 0;
			slot_reading   = 0;
			used_from_slot = '0;
			total_loaded   = '0;
			total_taken    = '0;
			after_dropped  = 1'b0;
		endfunction

		// Returns 1 when a letter is dropped because every slot is taken.
		function bit load_byte(logic [7:0] b);
			logic [63:0] grown;
			bit          alpha;
			alpha = ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
				((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
			if (alpha) begin
				// A tail run whose count is still zero is renamed, not followed.
				if ((runs_open > 0) && (run_counts[runs_open - 1] == 0)) begin
					run_letters[runs_open - 1] = b;
					after_dropped = 1'b0;
					return 1'b0;
				end
				if (runs_open >= TB_RUN_SLOTS) begin
					after_dropped = 1'b1;
					return 1'b1;
				end
				run_letters[runs_open] = b;
				run_counts[runs_open]  = '0;
				runs_open++;
				after_dropped = 1'b0;
				return 1'b0;
			end
			if ((b >= CHAR_ZERO) && (b <= CHAR_NINE) && !after_dropped && (runs_open > 0)) begin
				grown = run_counts[runs_open - 1] * DECIMAL_BASE + (b - CHAR_ZERO);
				if (grown > COUNT_CEILING)
					grown = COUNT_CEILING;
				total_loaded += grown - run_counts[runs_open - 1];
				run_counts[runs_open - 1] = grown;
			end
			return 1'b0;
		endfunction

		function logic [7:0] take_letter();
			if (total_taken >= total_loaded)
				return CHAR_SPACE;
			while ((slot_reading < runs_open) && (used_from_slot >= run_counts[slot_reading])) begin
				slot_reading++;
				used_from_slot = '0;
			end
			if (slot_reading >= runs_open)
				return CHAR_SPACE;
			used_from_slot++;
			total_taken++;
			return run_letters[slot_reading];
		endfunction

		function void note_input(logic [1:0] cmd, logic [7:0] b);
			rlsi_result_t want;
			want.out_char   = CHAR_SPACE;
			want.table_full = 1'b0;
			inputs_seen++;
			case (cmd)
				CMD_LOAD:  want.table_full = load_byte(b);
				CMD_TAKE:  want.out_char = take_letter();
				CMD_CLEAR: empty_table();
				default:   ;
			endcase
			want.has_more = (total_taken < total_loaded);
			expected_q.insert(expected_q.size(), want);
		endfunction

		function void flag_error(string msg);
			if (failures < REPORT_LIMIT)
				$display("%s", msg);
			failures++;
		endfunction

		function void check_result(logic [15:0] data);
			rlsi_result_t got;
			rlsi_result_t want;
			got.out_char   = data[7:0];
			got.has_more   = data[8];
			got.table_full = data[9];
			results_seen++;
			if (expected_q.size() == 0) begin
				flag_error($sformatf("result %0d unexpected: out_char %0d has_more %0b table_full %0b",
					results_seen, got.out_char, got.has_more, got.table_full));
				return;
			end
			want = expected_q.pop_front();
			if ((got.out_char !== want.out_char) || (got.has_more !== want.has_more) ||
				(got.table_full !== want.table_full)) begin
				flag_error($sformatf({"result %0d mismatch: expected out_char %0d has_more %0b ",
					"table_full %0b, got out_char %0d has_more %0b table_full %0b"},
					results_seen, want.out_char, want.has_more, want.table_full,
					got.out_char, got.has_more, got.table_full));
			end
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		// Letters still to hand out, capped so that callers can size a burst of takes.
		function int letters_left();
			logic [63:0] diff;
			diff = total_loaded - total_taken;
			return (diff > 64'd1000) ? 1000 : int'(diff);
		endfunction

		function void close_out();
			if (expected_q.size() != 0)
				flag_error($sformatf("%0d expected results never arrived", expected_q.size()));
		endfunction
	endclass

endpackage

FILE: tb/sv/run_length_string_iterator_tb.sv
// Top-level testbench for the run-length string iterator: drives directed and
// random command streams with random idling on both sides and checks every result.
// Depends on rlsi_pkg, rlsi_scoreboard_pkg and the run_length_string_iterator RTL.

module run_length_string_iterator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import rlsi_pkg::*;
	import rlsi_scoreboard_pkg::*;

	localparam logic [1:0] CMD_UNUSED      = 2'd3;
	localparam int         RANDOM_ITEMS    = 1550;
	localparam int         PRESSURE_AFTER  = 300;
	localparam int         HOLD_OFF_CYCLES = 250;
	localparam int         DRAIN_LIMIT     = 20000;
	localparam int         SETTLE_CYCLES   = 8;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	rlsi_scoreboard sb = new();
	int             items_sent = 0;
	bit             sender_burst = 1'b0;

	run_length_string_iterator #(
		.RUN_SLOTS  (TB_RUN_SLOTS),
		.COUNT_BITS (TB_COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_letter();
		int pick;
		pick = $urandom_range(0, 51);
		return (pick < 26) ? CHAR_UPPER_A + 8'(pick) : CHAR_LOWER_A + 8'(pick - 26);
	endfunction

	function automatic logic [7:0] rand_digit(input int lo, input int hi);
		return CHAR_ZERO + 8'($urandom_range(hi, lo));
	endfunction

	// Bytes right next to the letter and digit ranges are the likeliest to be misclassified.
	function automatic logic [7:0] rand_noise();
		case ($urandom_range(0, 9))
			0:       return CHAR_ZERO - 8'd1;
			1:       return CHAR_NINE + 8'd1;
			2:       return CHAR_UPPER_A - 8'd1;
			3:       return CHAR_UPPER_Z + 8'd1;
			4:       return CHAR_LOWER_A - 8'd1;
			5:       return CHAR_LOWER_Z + 8'd1;
			6:       return CHAR_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] value, input bit counts);
		int gap;
		gap = sender_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= value;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(cmd, value);
		if (counts)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [7:0] value);
		send_item(CMD_LOAD, value, 1'b1);
	endtask

	task automatic send_take();
		send_item(CMD_TAKE, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_clear();
		send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_noise();
		send_item(CMD_LOAD, rand_noise(), 1'b0);
	endtask

	task automatic load_run(input int digits, input int first_min, input int digit_max);
		send_load(rand_letter());
		for (int i = 0; i < digits; i++)
			send_load(rand_digit((i == 0) ? first_min : 0, digit_max));
	endtask

	task automatic short_episode();
		int runs;
		int left;
		runs = $urandom_range(1, 6);
		for (int r = 0; r < runs; r++) begin
			// A bare letter leaves a zero-count run that the next letter renames.
			if ($urandom_range(0, 9) == 0)
				send_load(rand_letter());
			load_run(($urandom_range(0, 9) == 0) ? 2 : 1, ($urandom_range(0, 9) == 0) ? 0 : 1, 9);
			if ($urandom_range(0, 9) < 3)
				send_noise();
			if ($urandom_range(0, 9) < 3)
				repeat ($urandom_range(1, 4)) send_take();
			if ($urandom_range(0, 29) == 0)
				send_clear();
		end
		left = sb.letters_left();
		repeat (((left > 60) ? 60 : left) + $urandom_range(1, 3)) send_take();
	endtask

	task automatic fill_episode();
		int extra;
		int takes;
		send_clear();
		extra = $urandom_range(1, 5);
		for (int r = 0; r < TB_RUN_SLOTS + extra; r++) begin
			if ($urandom_range(0, 19) == 0)
				send_load(rand_letter());
			load_run(1, 1, 3);
			if ($urandom_range(0, 19) == 0)
				send_noise();
			if ($urandom_range(0, 19) == 0)
				send_take();
		end
		takes = ($urandom_range(0, 1) == 1) ? sb.letters_left() + 2 : $urandom_range(1, 20);
		repeat (takes) send_take();
	endtask

	task automatic saturate_episode();
		if ($urandom_range(0, 1) == 1)
			send_clear();
		load_run($urandom_range(10, 14), 1, 9);
		repeat ($urandom_range(1, 5)) send_take();
		send_load(rand_digit(0, 9));
		repeat ($urandom_range(1, 3)) send_take();
		send_clear();
	endtask

	task automatic scramble_episode();
		repeat ($urandom_range(8, 30)) begin
			if ($urandom_range(0, 19) == 0)
				send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
			else
				send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin : receiver
		int pick;
		int span;
		bit level;
		bit pressure_done;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 99);
			if (!pressure_done && (sb.inputs_seen >= PRESSURE_AFTER)) begin
				// Long hold-off so that the block fills and back-pressures its input.
				pressure_done = 1'b1;
				level = 1'b0;
				span  = HOLD_OFF_CYCLES;
			end else if (pick < 45) begin
				level = 1'b1;
				span  = $urandom_range(1, 8);
			end else if (pick < 75) begin
				level = 1'b0;
				span  = $urandom_range(1, 3);
			end else if (pick < 85) begin
				level = 1'b0;
				span  = $urandom_range(4, 12);
			end else if (pick < 88) begin
				level = 1'b0;
				span  = $urandom_range(20, 60);
			end else begin
				level = 1'b1;
				span  = $urandom_range(20, 80);
			end
			repeat (span) begin
				@(negedge clk);
				m_tready <= level;
			end
		end
	end

	initial begin : watchdog
		#12_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		string big_count;
		int    kind;
		int    drain_cycles;
		big_count = "4294967296";
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: empty take, stray bytes, renaming, unused code, overflow.
		send_take();
		send_load(CHAR_ZERO + 8'd7);
		send_load(8'hFF);
		send_load(CHAR_UPPER_A);
		send_load(CHAR_LOWER_Z);
		send_load(CHAR_ZERO);
		send_load(CHAR_UPPER_Z);
		send_load(CHAR_ZERO + 8'd2);
		send_item(CMD_UNUSED, CHAR_LOWER_A + 8'd1, 1'b1);
		send_take();
		send_take();
		send_load(CHAR_LOWER_A);
		for (int i = 0; i < big_count.len(); i++)
			send_load(big_count[i]);
		send_take();
		send_clear();

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			sender_burst = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 12)
				fill_episode();
			else if (kind < 24)
				saturate_episode();
			else if (kind < 34)
				scramble_episode();
			else begin
				if ($urandom_range(0, 4) != 0)
					send_clear();
				short_episode();
			end
		end
		s_tvalid <= 1'b0;

		drain_cycles = 0;
		while ((sb.outstanding() != 0) && (drain_cycles < DRAIN_LIMIT)) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
